@@ hw/rtl/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the alarm state table: operation codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

  // Fixed field widths of the channels
  localparam int FUNC_W   = 3;
  localparam int ID_IN_W  = 32;
  localparam int CNT_OUT_W = 6;

  // Operation codes; unused codes behave as a query
  typedef enum logic [FUNC_W-1:0] {
    FN_QUERY      = 3'd0,
    FN_SET_ACTIVE = 3'd1,
    FN_SET_BLOCK  = 3'd2,
    FN_ACK        = 3'd3,
    FN_RESTORE    = 3'd4,
    FN_CLEAR      = 3'd5
  } func_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming transaction, restart the scan
    logic scan;     // advance the table scan by one entry
    logic update;   // apply the operation and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // match found, every held entry compared, or clear-all
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ast_if.sv @@
// ----------------------------------------------------------------------------
// ast_in_if / ast_out_if
// Valid/ready channels of the alarm state table: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ast_in_if;
  import ast_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [ID_IN_W-1:0]  alarm_id;
  logic                flag_value;
  logic                ack_value;

  modport source (output valid, func, alarm_id, flag_value, ack_value, input ready);
  modport sink   (input valid, func, alarm_id, flag_value, ack_value, output ready);
endinterface

interface ast_out_if;
  import ast_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic                 is_active;
  logic                 is_acked;
  logic                 is_blocked;
  logic                 table_full_reject;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, found, is_active, is_acked, is_blocked,
                  table_full_reject, entry_count, input ready);
  modport sink   (input valid, found, is_active, is_acked, is_blocked,
                  table_full_reject, entry_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ast_ctrl.sv @@
// ----------------------------------------------------------------------------
// ast_ctrl
// Sequencer of the alarm state table: accept, scan the table, update.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output ast_pkg::cmd_t cmd,
  input  ast_pkg::sts_t sts
);
  import ast_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs; no transaction is taken while reset is held
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = rst_n;
        cmd.accept = in_valid && rst_n;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ast_dp.sv @@
// ----------------------------------------------------------------------------
// ast_dp
// Datapath of the alarm state table: entry memory, scan compare, flag
// update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_dp #(
  parameter int TABLE_ENTRIES = 32,
  parameter int ID_BITS       = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ast_pkg::FUNC_W-1:0]   in_func,
  input  logic [ast_pkg::ID_IN_W-1:0]  in_alarm_id,
  input  logic                         in_flag_value,
  input  logic                         in_ack_value,
  input  ast_pkg::cmd_t                cmd,
  output ast_pkg::sts_t                sts,
  ast_out_if.source                    out_chan
);
  import ast_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = ID_BITS + 3;   // {id, active, acked, blocked}

  // Entry memory
  logic [ENT_W-1:0] mem [TABLE_ENTRIES];
  logic [ENT_W-1:0] mem_q_r;

  // Latched transaction
  logic [FUNC_W-1:0]  func_r;
  logic [ID_BITS-1:0] id_r;
  logic               flag_r;
  logic               ack_r;

  // Scan state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] issue_idx_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [2:0]       hit_flags_r;

  // Result register
  logic                 out_valid_r;
  logic                 found_r, active_r, acked_r, blocked_r, reject_r;
  logic [CNT_OUT_W-1:0] cnt_out_r;

  logic issue_more;
  logic rd_en;
  logic rd_match;

  // Update results
  logic             need_insert, full, reject, have;
  logic             act_nxt, ack_nxt, blk_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W+5:0] cnt_ext;
  logic [CNT_OUT_W-1:0] cnt_sat;

  // Scan control
  assign issue_more = (issue_idx_r < count_r);
  assign rd_en      = cmd.scan && issue_more && !hit_r;
  assign rd_match   = rd_vld_r && !hit_r && (mem_q_r[ENT_W-1:3] == id_r);

  assign sts.scan_done = hit_r || (func_r == FN_CLEAR) || (!issue_more && !rd_vld_r);
  assign sts.out_free  = !out_valid_r || out_chan.ready;

  // Operation: flag update on the matched or inserted entry
  always_comb begin
    need_insert = ((func_r == FN_SET_ACTIVE) || (func_r == FN_SET_BLOCK)) && !hit_r;
    full        = (count_r == CNT_W'(TABLE_ENTRIES));
    reject      = need_insert && full;
    have        = hit_r || (need_insert && !full);
    act_nxt     = hit_r ? hit_flags_r[2] : 1'b0;
    ack_nxt     = hit_r ? hit_flags_r[1] : 1'b0;
    blk_nxt     = hit_r ? hit_flags_r[0] : 1'b0;
    wr_en       = 1'b0;
    count_nxt   = (need_insert && !full) ? count_r + CNT_W'(1) : count_r;
    wr_idx      = hit_r ? hit_idx_r : count_r[IDX_W-1:0];
    unique case (func_r)
      FN_SET_ACTIVE: begin
        wr_en = have;
        if (have && !blk_nxt && (act_nxt != flag_r)) begin
          act_nxt = flag_r;
          if (flag_r) ack_nxt = 1'b0;
        end
      end
      FN_SET_BLOCK: begin
        wr_en   = have;
        blk_nxt = flag_r;
        if (flag_r) act_nxt = 1'b0;
      end
      FN_ACK: begin
        wr_en   = have;
        ack_nxt = 1'b1;
      end
      FN_RESTORE: begin
        wr_en   = have;
        act_nxt = flag_r;
        ack_nxt = ack_r;
      end
      FN_CLEAR: begin
        have      = 1'b0;
        count_nxt = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    // entry count saturates at the field's maximum
    cnt_ext = (CNT_W + 6)'(count_nxt);
    if (cnt_ext > (CNT_W + 6)'({CNT_OUT_W{1'b1}})) begin
      cnt_sat = {CNT_OUT_W{1'b1}};
    end else begin
      cnt_sat = cnt_ext[CNT_OUT_W-1:0];
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.update && wr_en) begin
      mem[wr_idx] <= {id_r, act_nxt, ack_nxt, blk_nxt};
    end
    if (rd_en) begin
      mem_q_r <= mem[issue_idx_r[IDX_W-1:0]];
    end
  end

  // Transaction latch and scan pipeline (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r      <= in_func;
      id_r        <= ID_BITS'(in_alarm_id);
      flag_r      <= in_flag_value;
      ack_r       <= in_ack_value;
      issue_idx_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld_r <= rd_en;
      rd_idx_r <= issue_idx_r[IDX_W-1:0];
      if (rd_en) issue_idx_r <= issue_idx_r + CNT_W'(1);
      if (rd_match) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= rd_idx_r;
        hit_flags_r <= mem_q_r[2:0];
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      found_r   <= have;
      active_r  <= have && act_nxt;
      acked_r   <= have && ack_nxt;
      blocked_r <= !have || blk_nxt;
      reject_r  <= reject;
      cnt_out_r <= cnt_sat;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.found             = found_r;
  assign out_chan.is_active         = active_r;
  assign out_chan.is_acked          = acked_r;
  assign out_chan.is_blocked        = blocked_r;
  assign out_chan.table_full_reject = reject_r;
  assign out_chan.entry_count       = cnt_out_r;

endmodule

`default_nettype wire

@@ hw/rtl/alarm_state_table.sv @@
// A transaction is taken in the idle state; the scan then compares the held
// entries in turn, and the update applies the operation and loads the result.
// One transaction at a time: the next is taken in the idle state after the update.
// Clear-all ends the scan without comparing entries; a held result stalls the update.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
// alarm_state_table
// Table of alarms with active, acknowledged and blocked flags, filled in
// order of first activation or block and searched by a sequential scan.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_state_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int ID_BITS       = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ast_in_if.sink    in_chan,
  ast_out_if.source out_chan
);
  import ast_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  ast_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Table and result path
  ast_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_chan.func),
    .in_alarm_id   (in_chan.alarm_id),
    .in_flag_value (in_chan.flag_value),
    .in_ack_value  (in_chan.ack_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_chan      (out_chan)
  );

  // Checks
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> sts.out_free) else $error("update while result slot busy");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.update)) else $error("result without update");

  a_absent_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.found) |-> (out_chan.is_blocked && !out_chan.is_active
      && !out_chan.is_acked)) else $error("absent alarm not reported as blocked");

  a_reject_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.table_full_reject) |-> !out_chan.found)
    else $error("rejected insert reported as found");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alarm state table. A behavioral copy of the
// table predicts the flags and entry count for every accepted transaction.
// Each result is checked field by field against the oldest prediction.
// The stimulus runs a short directed pass, a full-table pass, a long output
// hold that fills the block and several random phases with varied idling.
// ----------------------------------------------------------------------------

module testbench;
  import ast_pkg::*;

  localparam int      TABLE_DEPTH      = 32;
  localparam int      ID_POOL_SIZE     = 40;
  localparam int      RANDOM_PER_PHASE = 460;
  localparam int      HOLD_CYCLES      = 400;
  localparam int      DRAIN_CYCLES     = TABLE_DEPTH + 8;
  localparam int      MAX_SEND_GAP     = 48;
  localparam longint  CYCLE_LIMIT      = 1000000;

  // Unused operation codes, expected to act as a query
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic                 found;
    logic                 is_active;
    logic                 is_acked;
    logic                 is_blocked;
    logic                 table_full_reject;
    logic [CNT_OUT_W-1:0] entry_count;
  } alarm_status_t;

  logic clk = 1'b0;
  logic rst_n;

  ast_in_if  in_chan ();
  ast_out_if out_chan ();

  alarm_state_table #(
    .TABLE_ENTRIES (TABLE_DEPTH),
    .ID_BITS       (ID_IN_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow alarm table
  logic [ID_IN_W-1:0] tbl_id      [TABLE_DEPTH];
  bit                 tbl_active  [TABLE_DEPTH];
  bit                 tbl_acked   [TABLE_DEPTH];
  bit                 tbl_blocked [TABLE_DEPTH];
  int                 tbl_used = 0;

  alarm_status_t      pending_status [$];
  logic [ID_IN_W-1:0] id_pool [ID_POOL_SIZE];

  // Traffic shaping
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_req_seq   = 0;
  int     hold_seen_seq  = 0;
  int     hold_left      = 0;
  bit     offering       = 1'b0;

  int     error_cnt  = 0;
  int     item_cnt   = 0;
  int     result_cnt = 0;
  int     reject_cnt = 0;
  longint cycle_cnt  = 0;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int find_alarm(logic [ID_IN_W-1:0] id);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Look up, or allocate the next free slot; flags a reject when full
  function automatic int find_or_insert(logic [ID_IN_W-1:0] id, output bit rejected);
    int k;
    rejected = 1'b0;
    k = find_alarm(id);
    if (k >= 0) return k;
    if (tbl_used >= TABLE_DEPTH) begin
      rejected = 1'b1;
      return -1;
    end
    k = tbl_used;
    tbl_id[k]      = id;
    tbl_active[k]  = 1'b0;
    tbl_acked[k]   = 1'b0;
    tbl_blocked[k] = 1'b0;
    tbl_used++;
    return k;
  endfunction

  function automatic alarm_status_t apply_alarm_op(logic [FUNC_W-1:0] op,
                                                   logic [ID_IN_W-1:0] id,
                                                   bit flag, bit ack);
    alarm_status_t st;
    int            k;
    bit            rejected;
    k        = -1;
    rejected = 1'b0;
    case (op)
      FN_SET_ACTIVE: begin
        k = find_or_insert(id, rejected);
        // blocked alarms ignore activation; a 0 -> 1 edge clears the ack
        if (k >= 0 && !tbl_blocked[k] && tbl_active[k] != flag) begin
          tbl_active[k] = flag;
          if (flag) tbl_acked[k] = 1'b0;
        end
      end
      FN_SET_BLOCK: begin
        k = find_or_insert(id, rejected);
        if (k >= 0) begin
          tbl_blocked[k] = flag;
          if (flag) tbl_active[k] = 1'b0;
        end
      end
      FN_ACK: begin
        k = find_alarm(id);
        if (k >= 0) tbl_acked[k] = 1'b1;
      end
      FN_RESTORE: begin
        // written even while blocked
        k = find_alarm(id);
        if (k >= 0) begin
          tbl_active[k] = flag;
          tbl_acked[k]  = ack;
        end
      end
      FN_CLEAR: tbl_used = 0;
      default:  k = find_alarm(id);
    endcase
    st.found             = (k >= 0);
    st.is_active         = (k >= 0) ? tbl_active[k] : 1'b0;
    st.is_acked          = (k >= 0) ? tbl_acked[k] : 1'b0;
    st.is_blocked        = (k >= 0) ? tbl_blocked[k] : 1'b1;
    st.table_full_reject = rejected;
    st.entry_count       = tbl_used[CNT_OUT_W-1:0];
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [ID_IN_W-1:0] id,
                         input bit flag, input bit ack);
    alarm_status_t st;
    in_chan.valid      <= 1'b1;
    in_chan.func       <= op;
    in_chan.alarm_id   <= id;
    in_chan.flag_value <= flag;
    in_chan.ack_value  <= ack;
    offering = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    st = apply_alarm_op(op, id, flag, ack);
    pending_status.push_back(st);
    item_cnt++;
    if (st.table_full_reject) reject_cnt++;
    // random gap of varying length so idle cycles land on every scan phase
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, MAX_SEND_GAP)) @(posedge clk);
    end
  endtask

  task automatic refresh_id_pool();
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom;
  endtask

  // Mostly ids from a small pool so lookups hit, with near-miss and stray ids
  task automatic send_random_op();
    int                 r;
    logic [ID_IN_W-1:0] id;
    logic [FUNC_W-1:0]  op;
    r = $urandom_range(99);
    if (r < 90)      id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
    else if (r < 95) id = id_pool[$urandom_range(ID_POOL_SIZE - 1)] ^ (32'd1 << $urandom_range(31));
    else             id = $urandom;
    r = $urandom_range(99);
    if (r < 1)       op = FN_CLEAR;
    else if (r < 16) op = FN_QUERY;
    else if (r < 46) op = FN_SET_ACTIVE;
    else if (r < 60) op = FN_SET_BLOCK;
    else if (r < 76) op = FN_ACK;
    else if (r < 95) op = FN_RESTORE;
    else if (r < 97) op = FN_SPARE_6;
    else             op = FN_SPARE_7;
    send_op(op, id, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    if (offering) begin
      in_chan.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern and long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_req_seq != hold_seen_seq) begin
      hold_seen_seq = hold_req_seq;
      hold_left     = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [CNT_OUT_W-1:0] want,
                             input logic [CNT_OUT_W-1:0] got);
    if (got !== want) begin
      error_cnt++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    alarm_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_status.size() == 0) begin
        error_cnt++;
        $display("%0t: result with no transaction pending: expected none, actual found=%b cnt=%0d",
                 $time, out_chan.found, out_chan.entry_count);
      end else begin
        want = pending_status.pop_front();
        result_cnt++;
        check_field("found", CNT_OUT_W'(want.found), CNT_OUT_W'(out_chan.found));
        check_field("is_active", CNT_OUT_W'(want.is_active), CNT_OUT_W'(out_chan.is_active));
        check_field("is_acked", CNT_OUT_W'(want.is_acked), CNT_OUT_W'(out_chan.is_acked));
        check_field("is_blocked", CNT_OUT_W'(want.is_blocked),
                    CNT_OUT_W'(out_chan.is_blocked));
        check_field("table_full_reject", CNT_OUT_W'(want.table_full_reject),
                    CNT_OUT_W'(out_chan.table_full_reject));
        check_field("entry_count", want.entry_count, out_chan.entry_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still pending", $time,
               pending_status.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Flag rules, id extremes, absent alarms, unused codes, clear-all
  task automatic test_directed();
    send_op(FN_CLEAR, '0, 1'b0, 1'b0);
    send_op(FN_QUERY, '0, 1'b0, 1'b0);
    send_op(FN_ACK, '0, 1'b0, 1'b0);
    send_op(FN_RESTORE, '0, 1'b1, 1'b1);
    send_op(FN_SET_ACTIVE, '0, 1'b1, 1'b0);
    send_op(FN_ACK, '0, 1'b0, 1'b0);
    send_op(FN_SET_ACTIVE, '0, 1'b1, 1'b0);
    send_op(FN_SET_ACTIVE, '0, 1'b0, 1'b1);
    send_op(FN_SET_ACTIVE, '0, 1'b1, 1'b1);
    send_op(FN_SET_BLOCK, '1, 1'b1, 1'b0);
    send_op(FN_SET_ACTIVE, '1, 1'b1, 1'b0);
    send_op(FN_RESTORE, '1, 1'b1, 1'b1);
    send_op(FN_SET_BLOCK, '1, 1'b0, 1'b1);
    send_op(FN_SET_BLOCK, '0, 1'b1, 1'b0);
    send_op(FN_SET_ACTIVE, '0, 1'b0, 1'b0);
    send_op(FN_SPARE_6, '0, 1'b1, 1'b1);
    send_op(FN_SPARE_7, '1, 1'b0, 1'b0);
    send_op(FN_QUERY, 32'h8000_0000, 1'b0, 1'b0);
    send_op(FN_SET_ACTIVE, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_op(FN_RESTORE, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_op(FN_CLEAR, '1, 1'b1, 1'b1);
    send_op(FN_QUERY, '0, 1'b0, 1'b0);
  endtask

  // Fill every slot, then try to add more
  task automatic test_table_full();
    logic [ID_IN_W-1:0] slot_id [TABLE_DEPTH];
    send_op(FN_CLEAR, '0, 1'b0, 1'b0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_id[i] = {i[7:0], 24'($urandom)};
      send_op(i[0] ? FN_SET_BLOCK : FN_SET_ACTIVE, slot_id[i], 1'($urandom_range(1)), 1'b0);
    end
    send_op(FN_SET_ACTIVE, 32'hFF00_0001, 1'b1, 1'b0);
    send_op(FN_SET_BLOCK, 32'hFF00_0002, 1'b1, 1'b0);
    send_op(FN_ACK, 32'hFF00_0003, 1'b0, 1'b0);
    send_op(FN_QUERY, slot_id[TABLE_DEPTH-1], 1'b0, 1'b0);
    send_op(FN_RESTORE, slot_id[0], 1'b1, 1'b1);
    send_op(FN_SET_ACTIVE, slot_id[4], 1'b1, 1'b0);
    send_op(FN_CLEAR, '0, 1'b0, 1'b0);
  endtask

  // Result side holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    refresh_id_pool();
    hold_req_seq++;
    repeat (16) send_random_op();
    wait_idle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    refresh_id_pool();
    repeat (RANDOM_PER_PHASE) send_random_op();
  endtask

  initial begin
    in_chan.valid      <= 1'b0;
    in_chan.func       <= FN_QUERY;
    in_chan.alarm_id   <= '0;
    in_chan.flag_value <= 1'b0;
    in_chan.ack_value  <= 1'b0;
    rst_n              <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(86, 0);
    test_random_phase(0, 86);
    test_random_phase(36, 36);
    wait_idle();

    $display("Checked %0d results for %0d transactions, %0d of them full-table rejects.",
             result_cnt, item_cnt, reject_cnt);
    $display("Ran directed flag rules, a full table, a long output hold and four idle mixes.");
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
